// File: hdl/two_stacks_shared_memory_core_macros.svh
// ----------------------------------------------------------------------------
// Two stacks in one store - assertion macros
// Concurrent assertion helpers, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef TWO_STACKS_SHARED_MEMORY_CORE_MACROS_SVH
`define TWO_STACKS_SHARED_MEMORY_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define TSSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define TSSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TSSM_ASSERT_NOW(lbl, ante, cons, msg)
`define TSSM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hdl/tssm_pkg.sv
// ----------------------------------------------------------------------------
// Two stacks in one store - package
// Item types, status codes and controller states.
// ----------------------------------------------------------------------------
package tssm_pkg;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_e;

  localparam logic [1:0] SEL_LOWER = 2'd1;
  localparam logic [1:0] SEL_UPPER = 2'd2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADSTK = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } tssm_state_e;

  typedef struct packed {
    logic               mode;
    logic [1:0]         stack_select;
    logic signed [31:0] push_key;
    logic [31:0]        push_value;
  } tssm_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] pop_key;
    logic [31:0]        pop_value;
    logic [7:0]         lower_depth;
    logic [7:0]         upper_depth;
  } tssm_out_t;

endpackage

// File: hdl/tssm_ram.sv
// ----------------------------------------------------------------------------
// Two stacks in one store - generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tssm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/two_stacks_shared_memory_core.sv
// ----------------------------------------------------------------------------
// Two stacks in one store - top level
// A lower stack grows up from entry 0 and an upper stack grows down from the
// last entry of one shared RAM. Each item is a push or a pop and yields one
// result item with a status, the popped entry and both stack depths.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+-------------------------
//   in      | input     | in_valid_i / in_ready_o | in_data_i  (tssm_in_t)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (tssm_out_t)
//
// A push, and any item that fails a check, is decided from the two depth
// registers and has its result registered at the accepting edge, where a
// push also writes the RAM. A successful pop reads the RAM (registered read)
// and S_READ registers the result from it. Reset clears both depths; the RAM
// needs no clearing pass. A new item is taken in S_IDLE while the result
// register is empty or draining; a stalled output holds it and blocks input.
// ----------------------------------------------------------------------------
module two_stacks_shared_memory_core #(
  parameter int STORE_DEPTH = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tssm_pkg::tssm_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tssm_pkg::tssm_out_t out_data_o
);

  import tssm_pkg::*;

`include "two_stacks_shared_memory_core_macros.svh"

  // Address width of the store and width of a depth counter, which must be
  // able to hold STORE_DEPTH itself.
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(STORE_DEPTH);
  localparam logic [CW-1:0] OneC   = CW'(1);

  tssm_state_e state_q, state_d;
  logic [CW-1:0] lower_q, lower_d;
  logic [CW-1:0] upper_q, upper_d;
  logic          out_valid_q, out_valid_d;
  tssm_out_t     out_data_q, out_data_d;

  logic          in_acc;
  logic          out_free;
  logic [CW:0]   count_sum;
  logic          store_full;
  logic          sel_empty;
  logic          pop_ok;
  logic [CW-1:0] wr_ptr;
  logic [CW-1:0] rd_ptr;
  logic          ram_we;
  logic          ram_re;
  logic [63:0]   ram_rdata;

  // The result register can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // The store is full when the two tops meet.
  assign count_sum  = {1'b0, lower_q} + {1'b0, upper_q};
  assign store_full = count_sum >= {1'b0, DepthC};

  // A pop tests the lower stack only for the lower selection; every other
  // selection, the invalid ones included, tests the upper stack.
  assign sel_empty = (in_data_i.stack_select == SEL_LOWER) ? (lower_q == '0)
                                                           : (upper_q == '0);

  // Top pointers: next free slot for a push, current top for a pop.
  assign wr_ptr = (in_data_i.stack_select == SEL_LOWER) ? lower_q
                                                        : (DepthC - OneC - upper_q);
  assign rd_ptr = (in_data_i.stack_select == SEL_LOWER) ? (lower_q - OneC)
                                                        : (DepthC - upper_q);

  always_comb begin
    state_d     = state_q;
    lower_d     = lower_q;
    upper_d     = upper_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    pop_ok      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_data_d.status    = ST_OK;
          out_data_d.pop_key   = '0;
          out_data_d.pop_value = '0;
          if (in_data_i.mode == MODE_PUSH) begin
            // Full check comes before the stack number check.
            if (store_full) begin
              out_data_d.status = ST_FULL;
            end else begin
              case (in_data_i.stack_select)
                SEL_LOWER: begin
                  ram_we  = 1'b1;
                  lower_d = lower_q + OneC;
                end
                SEL_UPPER: begin
                  ram_we  = 1'b1;
                  upper_d = upper_q + OneC;
                end
                default: begin
                  out_data_d.status = ST_BADSTK;
                end
              endcase
            end
          end else begin
            // Empty check comes before the stack number check.
            if (sel_empty) begin
              out_data_d.status = ST_EMPTY;
            end else begin
              case (in_data_i.stack_select)
                SEL_LOWER: begin
                  pop_ok  = 1'b1;
                  lower_d = lower_q - OneC;
                end
                SEL_UPPER: begin
                  pop_ok  = 1'b1;
                  upper_d = upper_q - OneC;
                end
                default: begin
                  out_data_d.status = ST_BADSTK;
                end
              endcase
            end
          end
          out_data_d.lower_depth = 8'(lower_d);
          out_data_d.upper_depth = 8'(upper_d);
          if (pop_ok) begin
            // The entry arrives from the RAM in the next cycle.
            ram_re  = 1'b1;
            state_d = S_READ;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      S_READ: begin
        // The result register was freed when the pop was accepted, and the
        // depth registers already hold the values after the pop.
        out_data_d.status      = ST_OK;
        out_data_d.pop_key     = ram_rdata[63:32];
        out_data_d.pop_value   = ram_rdata[31:0];
        out_data_d.lower_depth = 8'(lower_q);
        out_data_d.upper_depth = 8'(upper_q);
        out_valid_d            = 1'b1;
        state_d                = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lower_q     <= '0;
      upper_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lower_q     <= lower_d;
      upper_q     <= upper_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  // Each entry holds the key in the upper half and the value bits below.
  tssm_ram #(
    .WIDTH (64),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr[AW-1:0]),
    .wdata_i ({in_data_i.push_key, in_data_i.push_value}),
    .re_i    (ram_re),
    .raddr_i (rd_ptr[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The two stacks together never hold more entries than the store has.
  `TSSM_ASSERT_NOW(a_no_overlap, 1'b1, count_sum <= {1'b0, DepthC}, "stacks overlap")

  // While a pop waits on the RAM, the result register is free for it.
  `TSSM_ASSERT_NOW(a_read_slot_free, state_q == S_READ, !out_valid_q, "result slot busy")

  // A successful pop always moves on to pick up its entry from the RAM.
  `TSSM_ASSERT_NEXT(a_pop_reads, pop_ok, state_q == S_READ && out_valid_q == 1'b0, "pop lost")

  // Every read cycle delivers a result in the cycle after it.
  `TSSM_ASSERT_NEXT(a_read_delivers, state_q == S_READ, out_valid_q && state_q == S_IDLE, "no result")

endmodule
